### design/otb_pkg.sv
// ----------------------------------------------------------------------------
// otb_pkg: shared types and codes for the one-shot timer bank
// Word layouts for both channels, operation codes and the store command.
// ----------------------------------------------------------------------------
package otb_pkg;

    localparam int OTB_SLOTS = 16;
    localparam int OP_W      = 3;
    localparam int SLOT_W    = 5;
    localparam int TICK_W    = 16;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL = 3'd2;
    localparam logic [OP_W-1:0] OP_CHECK  = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot_id;
        logic [TICK_W-1:0] delay_ticks;
    } t_in_word;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot_out;
        logic              expired;
    } t_out_word;

    // One write port and one read address into the slot store.
    typedef struct packed {
        logic              clear;
        logic              wr_target;
        logic              wr_count;
        logic [SLOT_W-1:0] addr;
        logic [TICK_W-1:0] target;
        logic [TICK_W-1:0] count;
    } t_store_cmd;

endpackage

### design/otb_store.sv
// ----------------------------------------------------------------------------
// otb_store: per-slot target and counter registers
// One addressed write and read per cycle; a clear empties every slot at once.
// ----------------------------------------------------------------------------
module otb_store
    import otb_pkg::*;
#(
    parameter int SLOTS = OTB_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_cmd        i_cmd,
    output logic [TICK_W-1:0] o_rd_target,
    output logic [TICK_W-1:0] o_rd_count
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [TICK_W-1:0] r_target [SLOTS];
    logic [TICK_W-1:0] r_count  [SLOTS];
    logic [IDX_W-1:0]  addr;

    assign addr        = i_cmd.addr[IDX_W-1:0];
    assign o_rd_target = r_target[addr];
    assign o_rd_count  = r_count[addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_target[i] <= '0;
                r_count[i]  <= '0;
            end
        end else begin
            if (i_cmd.wr_target) begin
                r_target[addr] <= i_cmd.target;
            end
            if (i_cmd.wr_count) begin
                r_count[addr] <= i_cmd.count;
            end
        end
    end

endmodule

### design/one_shot_timer_bank.sv
// ----------------------------------------------------------------------------
// one_shot_timer_bank: pool of one-shot timers
// Start, cancel, check and tick operations over a bank of 16-bit timers.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Word
// in       input      i_in_valid / o_in_stall   t_in_word  (op, slot_id, delay_ticks)
// out      output     o_out_valid / i_out_stall t_out_word (status, slot_out, expired)
//
// A tick with active slots, and a start that looks for a free slot, walk the
// slots one per cycle through a single incrementer/test.
// Check reads its slot in a state of its own (S_CHECK) before its result is ready.
// Reset (synchronous, i_rst_n low) and the reset-all operation clear every slot.
// A finished word waits in the output register while the next word is taken;
// a result not yet handed to it holds the sequencer until i_out_stall drops.
// ----------------------------------------------------------------------------
module one_shot_timer_bank
    import otb_pkg::*;
#(
    parameter int SLOTS = OTB_SLOTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [SLOT_W-1:0] NONE_CODE = SLOT_W'((SLOTS < 32) ? SLOTS : 31);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TICK  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_sid, n_sid;
    logic [TICK_W-1:0] r_delay, n_delay;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [SLOTS-1:0]  r_mask, n_mask;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_out_word         r_res, n_res;
    t_out_word         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    t_store_cmd        cmd;
    logic [TICK_W-1:0] rd_target;
    logic [TICK_W-1:0] rd_count;
    logic              in_ok;
    logic [IDX_W-1:0]  in_idx;
    logic [IDX_W-1:0]  sid_idx;

    otb_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_rd_target (rd_target),
        .o_rd_count  (rd_count)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_ok   = ({1'b0, i_in_data.slot_id} < (SLOT_W + 1)'(SLOTS));
    assign in_idx  = i_in_data.slot_id[IDX_W-1:0];
    assign sid_idx = r_sid[IDX_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_sid       = r_sid;
        n_delay     = r_delay;
        n_idx       = r_idx;
        n_mask      = r_mask;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        cmd         = '0;
        cmd.addr    = SLOT_W'(r_idx);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sid            = i_in_data.slot_id;
                    n_delay          = i_in_data.delay_ticks;
                    n_idx            = '0;
                    n_res.status     = 1'b0;
                    n_res.slot_out   = in_ok ? i_in_data.slot_id : NONE_CODE;
                    n_res.expired    = 1'b0;
                    n_state          = S_DONE;
                    cmd.addr         = i_in_data.slot_id;
                    case (i_in_data.op)
                        OP_TICK: begin
                            if (r_cnt != '0) begin
                                n_state = S_TICK;
                            end
                        end
                        OP_START: begin
                            if (r_cnt >= CNT_W'(SLOTS)) begin
                                n_res.status = 1'b1;
                            end else if (in_ok) begin
                                cmd.wr_target = 1'b1;
                                cmd.wr_count  = 1'b1;
                                cmd.target    = i_in_data.delay_ticks;
                                cmd.count     = '0;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        OP_CANCEL: begin
                            n_res.slot_out = NONE_CODE;
                            if (in_ok) begin
                                n_mask[in_idx] = 1'b0;
                                cmd.wr_target  = 1'b1;
                                cmd.target     = '0;
                                if (r_cnt != '0) begin
                                    n_cnt = r_cnt - CNT_W'(1);
                                end else begin
                                    n_res.status = 1'b1;
                                end
                            end
                        end
                        OP_CHECK: begin
                            if (in_ok) begin
                                n_state = S_CHECK;
                            end else begin
                                n_res.expired = 1'b1;
                            end
                        end
                        OP_RESET: begin
                            cmd.clear = 1'b1;
                            n_mask    = '0;
                            n_cnt     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_TICK: begin
                // advance every active counter, one slot a cycle
                if (r_mask[r_idx]) begin
                    cmd.wr_count = 1'b1;
                    cmd.count    = rd_count + 16'd1;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_FIND: begin
                // claim the lowest free slot
                if (!r_mask[r_idx]) begin
                    cmd.wr_target  = 1'b1;
                    cmd.wr_count   = 1'b1;
                    cmd.target     = r_delay;
                    cmd.count      = '0;
                    n_mask[r_idx]  = 1'b1;
                    n_cnt          = r_cnt + CNT_W'(1);
                    n_res.slot_out = SLOT_W'(r_idx);
                    n_state        = S_DONE;
                end else if (r_idx == LAST_IDX) begin
                    n_res.status   = 1'b1;
                    n_res.slot_out = NONE_CODE;
                    n_state        = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_CHECK: begin
                cmd.addr = r_sid;
                n_state  = S_DONE;
                if (!r_mask[sid_idx]) begin
                    n_res.expired = 1'b1;
                end else if (rd_target <= rd_count) begin
                    // elapsed: free the slot
                    n_mask[sid_idx] = 1'b0;
                    cmd.wr_target   = 1'b1;
                    cmd.target      = '0;
                    n_res.slot_out  = NONE_CODE;
                    if (r_cnt != '0) begin
                        n_cnt         = r_cnt - CNT_W'(1);
                        n_res.expired = 1'b1;
                    end else begin
                        n_res.status = 1'b1;
                    end
                end
            end
            S_DONE: begin
                // hand the word over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_mask      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_mask      <= n_mask;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sid   <= n_sid;
        r_delay <= n_delay;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

### sim/one_shot_timer_bank_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_shot_timer_bank_tb: self-checking bench for the one-shot timer bank
// Drives directed and random command words through the input channel, tracks
// the slot pool in a scoreboard and checks every reply word field by field,
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module one_shot_timer_bank_tb;
    import otb_pkg::*;

    localparam int SLOTS = OTB_SLOTS;
    localparam logic [SLOT_W-1:0] SLOT_NONE = (SLOTS < 32) ? SLOT_W'(SLOTS) : 5'd31;
    localparam int RANDOM_WORDS = 1600;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE       = 3 * (SLOTS + 2);

    // Pool state mirror and the queue of replies still owed by the block.
    class timer_pool_scoreboard;
        logic [SLOTS-1:0]  busy_mask;
        int unsigned       busy_count;
        logic [TICK_W-1:0] target_mem [SLOTS];
        logic [TICK_W-1:0] elapsed_mem [SLOTS];
        t_out_word         pending_replies [$];
        int mismatches;
        int replies_seen;
        int nospace_hits;
        int underflow_hits;
        int expiry_hits;
        int op_hits [8];

        function new();
            clear_all();
            mismatches     = 0;
            replies_seen   = 0;
            nospace_hits   = 0;
            underflow_hits = 0;
            expiry_hits    = 0;
            foreach (op_hits[i]) op_hits[i] = 0;
        endfunction

        function void clear_all();
            busy_mask  = '0;
            busy_count = 0;
            foreach (target_mem[i]) begin
                target_mem[i]  = '0;
                elapsed_mem[i] = '0;
            end
        endfunction

        // Free one slot; returns 1 when the active count was already zero.
        function logic release_slot(int s);
            busy_mask[s]  = 1'b0;
            target_mem[s] = '0;
            if (busy_count > 0) begin
                busy_count--;
                return 1'b0;
            end
            underflow_hits++;
            return 1'b1;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%0t: %s", $time, msg);
        endfunction

        function void note_command(t_in_word w);
            t_out_word r;
            int sid;
            int free_idx;
            sid       = w.slot_id;
            r.status  = 1'b0;
            r.expired = 1'b0;
            r.slot_out = (sid < SLOTS) ? SLOT_W'(sid) : SLOT_NONE;
            op_hits[w.op]++;
            case (w.op)
                OP_TICK: begin
                    if (busy_count > 0) begin
                        foreach (elapsed_mem[i]) begin
                            if (busy_mask[i]) elapsed_mem[i] = elapsed_mem[i] + 1'b1;
                        end
                    end
                end
                OP_START: begin
                    if (busy_count >= SLOTS) begin
                        r.status = 1'b1;
                    end else if (sid < SLOTS) begin
                        target_mem[sid]  = w.delay_ticks;
                        elapsed_mem[sid] = '0;
                    end else begin
                        free_idx = -1;
                        for (int i = SLOTS - 1; i >= 0; i--) begin
                            if (!busy_mask[i]) free_idx = i;
                        end
                        if (free_idx >= 0) begin
                            target_mem[free_idx]  = w.delay_ticks;
                            elapsed_mem[free_idx] = '0;
                            busy_mask[free_idx]   = 1'b1;
                            busy_count++;
                            r.slot_out = SLOT_W'(free_idx);
                        end else begin
                            r.status   = 1'b1;
                            r.slot_out = SLOT_NONE;
                        end
                    end
                    if (r.status) nospace_hits++;
                end
                OP_CANCEL: begin
                    if (sid < SLOTS) r.status = release_slot(sid);
                    r.slot_out = SLOT_NONE;
                end
                OP_CHECK: begin
                    if (sid < SLOTS && busy_mask[sid]) begin
                        if (target_mem[sid] <= elapsed_mem[sid]) begin
                            r.status   = release_slot(sid);
                            r.expired  = !r.status;
                            r.slot_out = SLOT_NONE;
                        end
                    end else begin
                        r.expired = 1'b1;
                    end
                    if (r.expired) expiry_hits++;
                end
                OP_RESET: clear_all();
                default: ;
            endcase
            pending_replies.push_back(r);
        endfunction

        function void check_reply(t_out_word got);
            t_out_word want;
            replies_seen++;
            if (pending_replies.size() == 0) begin
                flag($sformatf("unexpected reply: status %0b slot %0d expired %0b",
                               got.status, got.slot_out, got.expired));
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status || got.slot_out !== want.slot_out ||
                    got.expired !== want.expired) begin
                flag($sformatf({"reply mismatch: status %0b/%0b slot %0d/%0d ",
                                "expired %0b/%0b (expected/actual)"},
                               want.status, got.status, want.slot_out, got.slot_out,
                               want.expired, got.expired));
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_data;

    timer_pool_scoreboard sb;
    int cycles;
    int n_sent;
    int tx_idle_pct;
    int rx_idle_pct;
    int tx_quiet;
    int rx_quiet;

    one_shot_timer_bank #(
        .SLOTS (SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d replies outstanding",
                 cycles, sb.pending_replies.size());
        $display("FAIL one_shot_timer_bank");
        $finish;
    end

    // Receiver side: random stall with occasional quiet stretches.
    always @(negedge i_clk) begin
        if (rx_quiet > 0) begin
            rx_quiet--;
            i_out_stall = 1'b0;
        end else if ($urandom_range(0, 199) == 0) begin
            rx_quiet    = $urandom_range(20, 60);
            i_out_stall = 1'b0;
        end else begin
            i_out_stall = ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_reply(o_out_data);
    end

    function automatic t_in_word make_cmd(logic [OP_W-1:0] op, int sid,
                                          logic [TICK_W-1:0] dly);
        t_in_word w;
        w.op          = op;
        w.slot_id     = SLOT_W'(sid);
        w.delay_ticks = dly;
        return w;
    endfunction

    // Mostly short delays so that timers actually run out.
    function automatic logic [TICK_W-1:0] pick_delay();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return TICK_W'($urandom_range(0, 12));
        if (roll < 90) return TICK_W'($urandom);
        return (roll < 95) ? '0 : '1;
    endfunction

    function automatic int no_slot();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(SLOTS + 1, 31) : SLOTS;
    endfunction

    // A random active slot, or any in-range slot when none is active.
    function automatic int pick_held();
        int held [$];
        for (int i = 0; i < SLOTS; i++) begin
            if (sb.busy_mask[i]) held.push_back(i);
        end
        if (held.size() == 0) return $urandom_range(0, SLOTS - 1);
        return held[$urandom_range(0, held.size() - 1)];
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_cmd(input t_in_word w);
        int gap;
        gap = 0;
        if (tx_quiet > 0) begin
            tx_quiet--;
        end else if ($urandom_range(0, 49) == 0) begin
            tx_quiet = $urandom_range(15, 40);
        end else if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(w);
        if (w.op <= OP_RESET) n_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_directed();
        send_cmd(make_cmd(OP_TICK,   SLOTS, 16'h0000));
        send_cmd(make_cmd(OP_START,  SLOTS, 16'h0000));
        send_cmd(make_cmd(OP_CHECK,  0,     16'h0000));
        send_cmd(make_cmd(OP_CANCEL, 0,     16'h0000));  // underflow
        send_cmd(make_cmd(OP_START,  SLOTS, 16'hFFFF));
        send_cmd(make_cmd(OP_START,  31,    16'h0003));
        send_cmd(make_cmd(OP_START,  1,     16'h0001));  // reload held slot
        send_cmd(make_cmd(OP_START,  9,     16'h0005));  // reload inactive slot
        send_cmd(make_cmd(OP_TICK,   SLOTS, 16'h0000));
        send_cmd(make_cmd(OP_CHECK,  0,     16'h0000));
        send_cmd(make_cmd(OP_CHECK,  1,     16'h0000));
        send_cmd(make_cmd(OP_CHECK,  9,     16'h0000));
        send_cmd(make_cmd(OP_CHECK,  SLOTS, 16'h0000));
        send_cmd(make_cmd(OP_CANCEL, 9,     16'h0000));  // inactive, still lowers count
        send_cmd(make_cmd(OP_CANCEL, SLOTS, 16'h0000));
        send_cmd(make_cmd(OP_CANCEL, 31,    16'hFFFF));
        send_cmd(make_cmd(OP_TICK,   0,     16'h0000));  // count zero: no advance
        send_cmd(make_cmd(OP_CHECK,  0,     16'h0000));  // active slot, not yet elapsed, count zero
        send_cmd(make_cmd(3'd5,      31,    16'hFFFF));
        send_cmd(make_cmd(3'd6,      SLOTS, 16'h0000));
        send_cmd(make_cmd(3'd7,      3,     16'h5555));
        send_cmd(make_cmd(OP_TICK,   31,    16'hAAAA));
        send_cmd(make_cmd(OP_RESET,  7,     16'h1234));
        send_cmd(make_cmd(OP_START,  SLOTS, 16'hAAAA));
        send_cmd(make_cmd(OP_START,  30,    16'h5555));
    endtask

    task automatic run_random(input int upto);
        int kind;
        int s;
        while (n_sent < upto) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                // arm a few timers, let them run, then poll
                repeat ($urandom_range(1, 4))
                    send_cmd(make_cmd(OP_START, no_slot(), pick_delay()));
                repeat ($urandom_range(0, 10))
                    send_cmd(make_cmd(OP_TICK, $urandom_range(0, 31), TICK_W'($urandom)));
                repeat ($urandom_range(1, 5))
                    send_cmd(make_cmd(OP_CHECK, pick_held(), TICK_W'($urandom)));
            end else if (kind < 42) begin
                // push toward a full pool
                repeat ($urandom_range(12, 18))
                    send_cmd(make_cmd(OP_START, no_slot(), pick_delay()));
            end else if (kind < 55) begin
                s = ($urandom_range(0, 1) == 0) ? pick_held() : $urandom_range(0, SLOTS - 1);
                send_cmd(make_cmd(OP_START, s, pick_delay()));
                repeat ($urandom_range(0, 8)) send_cmd(make_cmd(OP_TICK, s, 16'h0000));
                send_cmd(make_cmd(OP_CHECK, s, 16'h0000));
            end else if (kind < 67) begin
                repeat ($urandom_range(1, 4)) begin
                    s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : pick_held();
                    send_cmd(make_cmd(OP_CANCEL, s, TICK_W'($urandom)));
                end
            end else if (kind < 71) begin
                send_cmd(make_cmd(OP_RESET, $urandom_range(0, 31), TICK_W'($urandom)));
            end else begin
                send_cmd(make_cmd(OP_W'($urandom_range(0, 7)), $urandom_range(0, 31),
                                  TICK_W'($urandom)));
            end
        end
    endtask

    initial begin
        int base;
        int waited;
        sb          = new();
        cycles      = 0;
        n_sent      = 0;
        tx_quiet    = 0;
        rx_quiet    = 0;
        tx_idle_pct = 24;
        rx_idle_pct = 52;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        base = n_sent;
        run_random(base + RANDOM_WORDS / 3);
        tx_idle_pct = 52;
        rx_idle_pct = 24;
        run_random(base + 2 * RANDOM_WORDS / 3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(base + RANDOM_WORDS);
        i_in_valid = 1'b0;

        waited = 0;
        while (sb.pending_replies.size() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (sb.pending_replies.size() > 0)
            sb.flag($sformatf("%0d replies never arrived", sb.pending_replies.size()));

        $display("run covered %0d words (tick %0d, start %0d, cancel %0d, check %0d, clear %0d)",
                 n_sent, sb.op_hits[OP_TICK], sb.op_hits[OP_START], sb.op_hits[OP_CANCEL],
                 sb.op_hits[OP_CHECK], sb.op_hits[OP_RESET]);
        $display("%0d replies checked: %0d pool full, %0d count underflow, %0d expiries, %0d bad",
                 sb.replies_seen, sb.nospace_hits, sb.underflow_hits, sb.expiry_hits,
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("PASS one_shot_timer_bank");
        end else begin
            $display("FAIL one_shot_timer_bank");
        end
        $finish;
    end

endmodule
